// ===== rtl/cut_cell_laplacian_stencil_core_assert.svh =====
// ---------------------------------------------------------------------------
// Cut-cell Laplacian stencil core assertion macros
// Concurrent assertion wrappers clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CUT_CELL_LAPLACIAN_STENCIL_CORE_ASSERT_SVH
`define CUT_CELL_LAPLACIAN_STENCIL_CORE_ASSERT_SVH

// same-cycle implication
`define CCLAP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cclap assertion failed");

// next-cycle implication
`define CCLAP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cclap assertion failed");

`endif

// ===== rtl/cclap_pkg.sv =====
// ---------------------------------------------------------------------------
// Cut-cell Laplacian stencil package
// Shared widths, register indexes and pipeline payload types.
// ---------------------------------------------------------------------------
package cclap_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_D    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_Y = 2'd3;

    localparam logic [31:0] COEF_C_RST    = 32'h0000_0000;
    localparam logic [31:0] COEF_D_RST    = 32'h0001_0000;
    localparam logic [31:0] SPACING_X_RST = 32'h0001_0000;
    localparam logic [31:0] SPACING_Y_RST = 32'h0001_0000;

    localparam logic [32:0] EPS_Q32 = 33'd4295;

    localparam int DIV_BITS = 61;
    localparam int NUM_W    = 115;
    localparam int DEN_W    = 97;
    localparam int REM_W    = 98;
    localparam int TERM_W   = 62;
    localparam int CR_W     = 48;

    localparam logic [TERM_W-1:0] TERM_LIMIT = 62'h1 << 60;

    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [DIV_BITS-1:0] quo;
        logic [DIV_BITS-1:0] nlo;
        logic [DEN_W-1:0]    den;
    } lane_t;

    typedef struct packed {
        logic                   zero;
        logic                   neg_x;
        logic                   neg_y;
        logic                   ovf_x;
        logic                   ovf_y;
        logic signed [CR_W-1:0] cr;
    } side_t;

endpackage

// ===== rtl/cclap_div_stage.sv =====
// ---------------------------------------------------------------------------
// Cut-cell Laplacian divider stage
// One registered restoring-division step: one quotient bit per stage.
// ---------------------------------------------------------------------------
module cclap_div_stage
(
    input  logic                 clk,
    input  logic                 en,
    input  cclap_pkg::lane_t     lane_in,
    output cclap_pkg::lane_t     lane_out
);

    logic [cclap_pkg::REM_W-1:0] rem_sh;
    logic                        ge;
    cclap_pkg::lane_t            lane_next;
    cclap_pkg::lane_t            lane_reg;

    always_comb
    begin
        rem_sh = {lane_in.rem[cclap_pkg::REM_W-2:0], lane_in.nlo[cclap_pkg::DIV_BITS-1]};
        ge     = rem_sh >= {1'b0, lane_in.den};
        lane_next.rem = ge ? (rem_sh - {1'b0, lane_in.den}) : rem_sh;
        lane_next.quo = {lane_in.quo[cclap_pkg::DIV_BITS-2:0], ge};
        lane_next.nlo = {lane_in.nlo[cclap_pkg::DIV_BITS-2:0], 1'b0};
        lane_next.den = lane_in.den;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

// ===== rtl/cut_cell_laplacian_stencil_core.sv =====
// ---------------------------------------------------------------------------
// Cut-cell Laplacian stencil core
// Per-cell 2D cut-cell Helmholtz action C*Q plus face-flux sum, Q16.16.
// ---------------------------------------------------------------------------
// One cell enters per clock while the output is not stalled, and passes six stages
// of products, sums and operand preparation, one stage per quotient bit of the
// 61-bit restoring divider for each axis, then rounding and the saturating sum.
// The whole pipeline holds only while a result at the output is stalled.
// Configuration must be written only while the pipeline is empty.
module cut_cell_laplacian_stencil_core
#(
    parameter int DATA_WIDTH = cclap_pkg::DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [31:0]           q_center,
    input  logic [31:0]           q_west,
    input  logic [31:0]           q_east,
    input  logic [31:0]           q_south,
    input  logic [31:0]           q_north,
    input  logic [16:0]           vol_fraction,
    input  logic [3:0]            neighbor_open,
    input  logic [16:0]           face_west,
    input  logic [16:0]           face_east,
    input  logic [16:0]           face_south,
    input  logic [16:0]           face_north,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_WIDTH-1:0] action_value,
    output logic                  saturated
);

    `include "cut_cell_laplacian_stencil_core_assert.svh"

    localparam int NDIV = cclap_pkg::DIV_BITS;
    localparam logic [63:0] HI_LIM = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
    localparam logic [63:0] LO_LIM = ~HI_LIM;

    logic [31:0] coef_c_reg, coef_d_reg, spacing_x_reg, spacing_y_reg;
    logic        cfg_wr;
    logic        en;
    logic [31:0] abs_d;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_c_reg    <= cclap_pkg::COEF_C_RST;
            coef_d_reg    <= cclap_pkg::COEF_D_RST;
            spacing_x_reg <= cclap_pkg::SPACING_X_RST;
            spacing_y_reg <= cclap_pkg::SPACING_Y_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                cclap_pkg::REG_COEF_C:    coef_c_reg    <= pwdata;
                cclap_pkg::REG_COEF_D:    coef_d_reg    <= pwdata;
                cclap_pkg::REG_SPACING_X: spacing_x_reg <= pwdata;
                cclap_pkg::REG_SPACING_Y: spacing_y_reg <= pwdata;
                default:                  coef_c_reg    <= coef_c_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            cclap_pkg::REG_COEF_C:    prdata = coef_c_reg;
            cclap_pkg::REG_COEF_D:    prdata = coef_d_reg;
            cclap_pkg::REG_SPACING_X: prdata = spacing_x_reg;
            cclap_pkg::REG_SPACING_Y: prdata = spacing_y_reg;
            default:                  prdata = '0;
        endcase
    end

    assign abs_d = coef_d_reg[31] ? (~coef_d_reg + 32'd1) : coef_d_reg;

    // global advance
    logic out_v_reg;
    assign en       = !(out_v_reg && out_stall);
    assign in_stall = !en;

    // stage 1: face products, C*Q, fe
    logic signed [32:0] dw, de, ds, dn;
    logic [16:0]        fw_m, fe_m, fs_m, fn_m;
    logic               s1_v_reg;
    logic signed [50:0] pw_reg, pe_reg, ps_reg, pn_reg;
    logic signed [63:0] cq_reg;
    logic [32:0]        fe_reg;
    logic               s1_zero_reg;

    always_comb
    begin
        dw   = $signed({q_west[31],  q_west})  - $signed({q_center[31], q_center});
        de   = $signed({q_east[31],  q_east})  - $signed({q_center[31], q_center});
        ds   = $signed({q_south[31], q_south}) - $signed({q_center[31], q_center});
        dn   = $signed({q_north[31], q_north}) - $signed({q_center[31], q_center});
        fw_m = neighbor_open[0] ? face_west  : 17'd0;
        fe_m = neighbor_open[1] ? face_east  : 17'd0;
        fs_m = neighbor_open[2] ? face_south : 17'd0;
        fn_m = neighbor_open[3] ? face_north : 17'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pw_reg      <= $signed({1'b0, fw_m}) * dw;
            pe_reg      <= $signed({1'b0, fe_m}) * de;
            ps_reg      <= $signed({1'b0, fs_m}) * ds;
            pn_reg      <= $signed({1'b0, fn_m}) * dn;
            cq_reg      <= $signed(q_center) * $signed(coef_c_reg);
            fe_reg      <= {vol_fraction, 16'd0} + cclap_pkg::EPS_Q32;
            s1_zero_reg <= (vol_fraction == 17'd0) || (spacing_x_reg == 32'd0)
                           || (spacing_y_reg == 32'd0);
        end
    end

    // stage 2: axis sums, h*h, rounded C*Q
    logic [63:0]        cq_mag, cq_rnd;
    logic [47:0]        cr_mag;
    logic               s2_v_reg;
    logic signed [51:0] sx_sum_reg, sy_sum_reg;
    logic [63:0]        hhx_reg, hhy_reg;
    logic [32:0]        s2_fe_reg;
    logic signed [47:0] s2_cr_reg;
    logic               s2_zero_reg;

    always_comb
    begin
        cq_mag = cq_reg[63] ? (~cq_reg + 64'd1) : cq_reg;
        cq_rnd = cq_mag + 64'h8000;
        cr_mag = cq_rnd[63:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_sum_reg  <= {pw_reg[50], pw_reg} + {pe_reg[50], pe_reg};
            sy_sum_reg  <= {ps_reg[50], ps_reg} + {pn_reg[50], pn_reg};
            hhx_reg     <= spacing_x_reg * spacing_x_reg;
            hhy_reg     <= spacing_y_reg * spacing_y_reg;
            s2_fe_reg   <= fe_reg;
            s2_cr_reg   <= cq_reg[63] ? $signed(~cr_mag + 48'd1) : $signed(cr_mag);
            s2_zero_reg <= s1_zero_reg;
        end
    end

    // stage 3: magnitudes, signs, denominator partial products
    logic [51:0]  sx_abs, sy_abs;
    logic         s3_v_reg;
    logic [50:0]  sx_abs_reg, sy_abs_reg;
    logic [64:0]  dpx_lo_reg, dpx_hi_reg, dpy_lo_reg, dpy_hi_reg;
    cclap_pkg::side_t s3_sb_reg;

    always_comb
    begin
        sx_abs = sx_sum_reg[51] ? (~sx_sum_reg + 52'd1) : sx_sum_reg;
        sy_abs = sy_sum_reg[51] ? (~sy_sum_reg + 52'd1) : sy_sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_abs_reg      <= sx_abs[50:0];
            sy_abs_reg      <= sy_abs[50:0];
            dpx_lo_reg      <= hhx_reg[31:0]  * s2_fe_reg;
            dpx_hi_reg      <= hhx_reg[63:32] * s2_fe_reg;
            dpy_lo_reg      <= hhy_reg[31:0]  * s2_fe_reg;
            dpy_hi_reg      <= hhy_reg[63:32] * s2_fe_reg;
            s3_sb_reg.zero  <= s2_zero_reg;
            s3_sb_reg.neg_x <= coef_d_reg[31] ^ sx_sum_reg[51];
            s3_sb_reg.neg_y <= coef_d_reg[31] ^ sy_sum_reg[51];
            s3_sb_reg.ovf_x <= 1'b0;
            s3_sb_reg.ovf_y <= 1'b0;
            s3_sb_reg.cr    <= s2_cr_reg;
        end
    end

    // stage 4: numerator partial products, denominators
    logic         s4_v_reg;
    logic [63:0]  nx_lo_reg, ny_lo_reg;
    logic [50:0]  nx_hi_reg, ny_hi_reg;
    logic [96:0]  denx_reg, deny_reg;
    cclap_pkg::side_t s4_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_lo_reg <= abs_d * sx_abs_reg[31:0];
            nx_hi_reg <= abs_d * sx_abs_reg[50:32];
            ny_lo_reg <= abs_d * sy_abs_reg[31:0];
            ny_hi_reg <= abs_d * sy_abs_reg[50:32];
            denx_reg  <= {32'd0, dpx_lo_reg} + {dpx_hi_reg, 32'd0};
            deny_reg  <= {32'd0, dpy_lo_reg} + {dpy_hi_reg, 32'd0};
            s4_sb_reg <= s3_sb_reg;
        end
    end

    // stage 5: numerators
    logic         s5_v_reg;
    logic [82:0]  prx_reg, pry_reg;
    logic [96:0]  s5_denx_reg, s5_deny_reg;
    cclap_pkg::side_t s5_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prx_reg     <= {nx_hi_reg, 32'd0} + {19'd0, nx_lo_reg};
            pry_reg     <= {ny_hi_reg, 32'd0} + {19'd0, ny_lo_reg};
            s5_denx_reg <= denx_reg;
            s5_deny_reg <= deny_reg;
            s5_sb_reg   <= s4_sb_reg;
        end
    end

    // stage 6: overflow test and divider load
    logic [cclap_pkg::NUM_W-1:0] numx, numy;
    logic             s6_v_reg;
    cclap_pkg::lane_t s6_lx_reg, s6_ly_reg;
    cclap_pkg::side_t s6_sb_reg;

    always_comb
    begin
        numx = {prx_reg, 32'd0};
        numy = {pry_reg, 32'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_lx_reg.rem   <= {44'd0, numx[114:61]};
            s6_lx_reg.quo   <= '0;
            s6_lx_reg.nlo   <= numx[60:0];
            s6_lx_reg.den   <= s5_denx_reg;
            s6_ly_reg.rem   <= {44'd0, numy[114:61]};
            s6_ly_reg.quo   <= '0;
            s6_ly_reg.nlo   <= numy[60:0];
            s6_ly_reg.den   <= s5_deny_reg;
            s6_sb_reg.zero  <= s5_sb_reg.zero;
            s6_sb_reg.neg_x <= s5_sb_reg.neg_x;
            s6_sb_reg.neg_y <= s5_sb_reg.neg_y;
            s6_sb_reg.ovf_x <= {43'd0, numx[114:61]} >= s5_denx_reg;
            s6_sb_reg.ovf_y <= {43'd0, numy[114:61]} >= s5_deny_reg;
            s6_sb_reg.cr    <= s5_sb_reg.cr;
        end
    end

    // divider pipeline
    cclap_pkg::lane_t lx_w [NDIV+1];
    cclap_pkg::lane_t ly_w [NDIV+1];
    logic             div_v_reg  [NDIV];
    cclap_pkg::side_t div_sb_reg [NDIV];

    assign lx_w[0] = s6_lx_reg;
    assign ly_w[0] = s6_ly_reg;

    genvar k;
    generate
        for (k = 0; k < NDIV; k++)
        begin : g_div
            cclap_div_stage u_x
            (
                .clk      (clk),
                .en       (en),
                .lane_in  (lx_w[k]),
                .lane_out (lx_w[k+1])
            );
            cclap_div_stage u_y
            (
                .clk      (clk),
                .en       (en),
                .lane_in  (ly_w[k]),
                .lane_out (ly_w[k+1])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    div_v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    div_v_reg[k] <= (k == 0) ? s6_v_reg : div_v_reg[(k == 0) ? 0 : k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    div_sb_reg[k] <= (k == 0) ? s6_sb_reg : div_sb_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    // final 1: round and clamp axis terms
    cclap_pkg::lane_t lx_end, ly_end;
    cclap_pkg::side_t sb_end;
    logic [cclap_pkg::TERM_W-1:0] qrx, qry, magx, magy;
    logic              f1_v_reg;
    logic [cclap_pkg::TERM_W-1:0] tx_reg, ty_reg;
    logic signed [cclap_pkg::CR_W-1:0] f1_cr_reg;
    logic              f1_zero_reg;

    always_comb
    begin
        lx_end = lx_w[NDIV];
        ly_end = ly_w[NDIV];
        sb_end = div_sb_reg[NDIV-1];
        qrx = {1'b0, lx_end.quo}
              + {61'd0, ({lx_end.rem, 1'b0} >= {2'b0, lx_end.den})};
        qry = {1'b0, ly_end.quo}
              + {61'd0, ({ly_end.rem, 1'b0} >= {2'b0, ly_end.den})};
        magx = (sb_end.ovf_x || (qrx > cclap_pkg::TERM_LIMIT)) ? cclap_pkg::TERM_LIMIT : qrx;
        magy = (sb_end.ovf_y || (qry > cclap_pkg::TERM_LIMIT)) ? cclap_pkg::TERM_LIMIT : qry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_v_reg <= div_v_reg[NDIV-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg      <= sb_end.neg_x ? (~magx + 62'd1) : magx;
            ty_reg      <= sb_end.neg_y ? (~magy + 62'd1) : magy;
            f1_cr_reg   <= sb_end.cr;
            f1_zero_reg <= sb_end.zero;
        end
    end

    // final 2: sum and saturate, or zero when the zero flag is set
    logic [63:0]           total;
    logic                  over_hi, under_lo;
    logic [DATA_WIDTH-1:0] av_next;
    logic                  sat_next;
    logic [DATA_WIDTH-1:0] av_reg;
    logic                  sat_reg;

    always_comb
    begin
        total = {{16{f1_cr_reg[47]}}, f1_cr_reg} + {{2{tx_reg[61]}}, tx_reg}
                + {{2{ty_reg[61]}}, ty_reg};
        over_hi  = $signed(total) > $signed(HI_LIM);
        under_lo = $signed(total) < $signed(LO_LIM);
        if (f1_zero_reg)
        begin
            av_next  = '0;
            sat_next = 1'b0;
        end
        else if (over_hi)
        begin
            av_next  = HI_LIM[DATA_WIDTH-1:0];
            sat_next = 1'b1;
        end
        else if (under_lo)
        begin
            av_next  = LO_LIM[DATA_WIDTH-1:0];
            sat_next = 1'b1;
        end
        else
        begin
            av_next  = total[DATA_WIDTH-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            av_reg  <= av_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid    = out_v_reg;
    assign action_value = av_reg;
    assign saturated    = sat_reg;

    `CCLAP_ASSERT_IMPL(a_sat_at_limit, out_v_reg && sat_reg,
        (av_reg == HI_LIM[DATA_WIDTH-1:0]) || (av_reg == LO_LIM[DATA_WIDTH-1:0]))
    `CCLAP_ASSERT_IMPL(a_div_rem_below_den,
        div_v_reg[NDIV-1] && !sb_end.ovf_x && !sb_end.zero,
        {1'b0, lx_end.den} > lx_end.rem)
    `CCLAP_ASSERT_NEXT(a_ovf_clamps,
        en && div_v_reg[NDIV-1] && sb_end.ovf_x && !sb_end.neg_x,
        tx_reg == cclap_pkg::TERM_LIMIT)

endmodule
